// ===== src/mrgs_pkg.sv =====
// package for merge_sort_batch: sizes, state type, control structs and value conversion
`timescale 1ns / 1ps

package mrgs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W      = CNT_W + 2;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic merge_init;
    logic merge_step;
    logic emit_init;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic sorted;
    logic pass_end;
    logic emit_last;
    logic out_free;
  } status_t;

  function automatic val_t to_store(input logic [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return val_t'(ext[VALUE_BITS-1:0]);
  endfunction

  function automatic logic [31:0] to_out(input val_t s);
    logic signed [63:0] ext;
    ext = 64'(s);
    return ext[31:0];
  endfunction

endpackage

// ===== src/merge_sort_batch.sv =====
// Sequence: n values load, then ceil(log2 n) merge passes run, each begun in the pass setup state,
// then the emit setup and n emit transfers follow; merging runs at one merge element a cycle.
// Throughput: one batch at a time; the next batch loads while the final result still waits.
// The merge rate is set by the two-read, one-write ping-pong stores.
// Reset (rst_n low, synchronous): batch count, overflow flag, state and output valid clear.
// Stores keep their contents and need no clearing.
`timescale 1ns / 1ps

module merge_sort_batch
  import mrgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sorted_value,
  output logic        out_end_of_batch,
  output logic        out_overflowed
);

  cmd_t    cmd;
  status_t status;

  mrgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mrgs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_ready        (out_ready),
    .status           (status),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_end_of_batch (out_end_of_batch),
    .out_overflowed   (out_overflowed)
  );

endmodule

// ===== src/mrgs_ctrl.sv =====
// controller for merge_sort_batch: load, pass setup, merge and emit sequencing
`timescale 1ns / 1ps

module mrgs_ctrl
  import mrgs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_PASS;
      end
      ST_PASS: begin
        state_nxt = status.sorted ? ST_EMIT : ST_MERGE;
      end
      ST_MERGE: begin
        if (status.pass_end) state_nxt = ST_PASS;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PASS: begin
        cmd.emit_init  = status.sorted;
        cmd.merge_init = !status.sorted;
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/mrgs_dp.sv =====
// datapath for merge_sort_batch: ping-pong stores, merge pointers, output register
`timescale 1ns / 1ps

module mrgs_dp
  import mrgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] in_value,
  input  logic        in_last,
  input  logic        out_ready,
  output status_t     status,
  output logic        out_valid,
  output logic [31:0] out_sorted_value,
  output logic        out_end_of_batch,
  output logic        out_overflowed
);

  val_t mem_a [MAX_ITEMS];
  val_t mem_b [MAX_ITEMS];

  val_t rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;

  cnt_t fill_r, fill_nxt;
  logic drop_r, drop_nxt;
  logic src_r, src_nxt;
  logic [CNT_W:0] width_r, width_nxt;
  cnt_t mid_r, mid_nxt;
  cnt_t hi_r, hi_nxt;
  cnt_t i_r, i_nxt;
  cnt_t j_r, j_nxt;
  cnt_t k_r, k_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic        out_end_r, out_ovf_r;

  val_t head_i, head_j, win;
  logic i_ok, j_ok, take_i;
  logic merge_end, pass_end, emit_last;
  logic has_room;
  logic setup;
  cnt_t base;
  logic [SUM_W-1:0] base_s, mid_s, hi_s, n_s;
  cnt_t setup_mid, setup_hi;

  assign head_i = src_r ? rd_b0_r : rd_a0_r;
  assign head_j = src_r ? rd_b1_r : rd_a1_r;
  assign i_ok   = i_r < mid_r;
  assign j_ok   = j_r < hi_r;
  assign take_i = i_ok && (!j_ok || (head_i <= head_j));
  assign win    = take_i ? head_i : head_j;

  assign merge_end = (k_r + CNT_W'(1)) == hi_r;
  assign pass_end  = merge_end && (hi_r == fill_r);
  assign emit_last = (i_r + CNT_W'(1)) == fill_r;
  assign has_room  = fill_r < CNT_W'(MAX_ITEMS);

  assign setup  = cmd.merge_init || (cmd.merge_step && merge_end && !pass_end);
  assign base   = cmd.merge_init ? '0 : hi_r;
  assign base_s = SUM_W'(base);
  assign n_s    = SUM_W'(fill_r);
  assign mid_s  = base_s + SUM_W'(width_r);
  assign hi_s   = base_s + SUM_W'({width_r, 1'b0});
  assign setup_mid = (mid_s > n_s) ? fill_r : mid_s[CNT_W-1:0];
  assign setup_hi  = (hi_s > n_s) ? fill_r : hi_s[CNT_W-1:0];

  always_comb begin
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    src_nxt       = src_r;
    width_nxt     = width_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      if (has_room) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_last) begin
        width_nxt = (CNT_W+1)'(1);
        src_nxt   = 1'b0;
      end
    end

    if (cmd.merge_step) begin
      i_nxt = i_r + CNT_W'(take_i);
      j_nxt = j_r + CNT_W'(!take_i);
      k_nxt = k_r + CNT_W'(1);
      if (pass_end) begin
        width_nxt = {width_r[CNT_W-1:0], 1'b0};
        src_nxt   = !src_r;
      end
    end

    if (setup) begin
      i_nxt   = base;
      j_nxt   = setup_mid;
      k_nxt   = base;
      mid_nxt = setup_mid;
      hi_nxt  = setup_hi;
    end

    if (cmd.emit_init) begin
      i_nxt = '0;
    end

    if (cmd.emit_step) begin
      i_nxt         = i_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
      if (emit_last) begin
        fill_nxt = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    width_r <= width_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    if (cmd.emit_step) begin
      out_value_r <= to_out(head_i);
      out_end_r   <= emit_last;
      out_ovf_r   <= drop_r;
    end
  end

  // store a: loaded values and even pass results
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem_a[fill_r[IDX_W-1:0]] <= to_store(in_value);
    end else if (cmd.merge_step && src_r) begin
      mem_a[k_r[IDX_W-1:0]] <= win;
    end
    rd_a0_r <= mem_a[i_nxt[IDX_W-1:0]];
    rd_a1_r <= mem_a[j_nxt[IDX_W-1:0]];
  end

  // store b: odd pass results
  always_ff @(posedge clk) begin
    if (cmd.merge_step && !src_r) begin
      mem_b[k_r[IDX_W-1:0]] <= win;
    end
    rd_b0_r <= mem_b[i_nxt[IDX_W-1:0]];
    rd_b1_r <= mem_b[j_nxt[IDX_W-1:0]];
  end

  assign status.sorted    = (width_r >= (CNT_W+1)'(fill_r));
  assign status.pass_end  = pass_end;
  assign status.emit_last = emit_last;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_batch = out_end_r;
  assign out_overflowed   = out_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_merge_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> ((CNT_W+1)'(k_r) + (CNT_W+1)'(mid_r)) ==
                       ((CNT_W+1)'(i_r) + (CNT_W+1)'(j_r)))
    else $error("merge write index out of step with run pointers");

  a_merge_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> (i_ok || j_ok))
    else $error("merge step with both runs empty");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_step && emit_last) |=> (fill_r == '0 && !drop_r))
    else $error("batch state not cleared after final transfer");

endmodule
